// ===== design/dhbc_pkg.sv =====
// Shared types and constants for the double-hash bucket counter.
package dhbc_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_NEW      = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_t;

  // Configuration register indexes.
  localparam logic [7:0] REG_VERIFY_BITS = 8'd0;
  localparam logic [7:0] REG_WEIGHTED    = 8'd1;
  localparam logic [7:0] REG_TAXA_COUNT  = 8'd2;

  // Field widths fixed by the interface.
  localparam int HASH_W     = 64;
  localparam int BITS_W     = 64;
  localparam int COUNT_W    = 16;
  localparam int BUCKET_IN_W = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Input word.
  typedef struct packed {
    logic [BUCKET_IN_W-1:0] bucket_hash;
    logic [HASH_W-1:0]      check_hash;
    logic [BITS_W-1:0]      bits;
    logic                   flip;
    logic [15:0]            tree_index;
    logic [31:0]            distance;
  } item_t;

  // Result word.
  typedef struct packed {
    status_t             status;
    logic [2:0]          slot;
    logic [COUNT_W-1:0]  hit_count;
    logic [15:0]         tree_out;
    logic [31:0]         weight_out;
    logic                weight_valid;
  } result_t;

  // Configuration write word.
  typedef struct packed {
    logic [7:0] reg_index;
    logic [6:0] reg_value;
  } cfg_t;

  // Outcome of one bucket row update.
  typedef struct packed {
    logic               we;
    status_t            status;
    logic [2:0]         slot;
    logic [COUNT_W-1:0] count;
  } upd_res_t;

endpackage

// ===== design/dhbc_chan_if.sv =====
// Valid/ready channel carrying one word of a given type.
interface dhbc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/double_hash_bucket_counter.sv =====
// Top level of the double-hash bucket counter: control, bucket row memory, results.
//
//   channel  dir  word                                        handshake
//   item     in   bucket_hash, check_hash, bits, flip,        valid/ready
//                 tree_index, distance
//   result   out  status, slot, hit_count, tree_out,          valid/ready
//                 weight_out, weight_valid
//   cfg      in   reg_index, reg_value                        valid/ready
//
// For each word the bucket row is first read from the single-port row memory;
// then all slots are compared in parallel and the row is written back.
// After reset a clearing pass writes zero to every row while item.ready
// stays low; cfg is always ready.
// A result that is not taken holds the compare stage; item.ready is high
// whenever the controller is idle, also while a result waits in its register.
module double_hash_bucket_counter #(
  parameter int BUCKETS  = 1024,
  parameter int WAYS     = 8,
  parameter int MAX_TAXA = 64
) (
  input  logic        clk,
  input  logic        rst,
  dhbc_chan_if.sink   item,
  dhbc_chan_if.source result,
  dhbc_chan_if.sink   cfg
);

  localparam int BW      = $clog2(BUCKETS);
  localparam int FILL_W  = $clog2(WAYS + 1);
  localparam int ENTRY_W = dhbc_pkg::HASH_W + dhbc_pkg::COUNT_W + MAX_TAXA;
  localparam int ROW_W   = FILL_W + WAYS * ENTRY_W;

  dhbc_pkg::state_t state, state_next;

  // Configuration registers.
  logic       verify_bits;
  logic       weighted;
  logic [6:0] taxa_count;

  // Clearing sweep.
  logic [BW-1:0] clr_addr;

  // Item held across the lookup.
  logic [BW-1:0]                 bucket_q;
  logic [dhbc_pkg::HASH_W-1:0]   check_q;
  logic [MAX_TAXA-1:0]           norm_q;
  logic [15:0]                   tree_q;
  logic [31:0]                   dist_q;

  // Result register.
  logic                          res_valid;
  dhbc_pkg::result_t             res_q;

  // Memory port.
  logic [BW-1:0]    ram_addr;
  logic             ram_we;
  logic [ROW_W-1:0] ram_wdata;
  logic             ram_re;
  logic [ROW_W-1:0] ram_rdata;

  logic [ROW_W-1:0]       row_new;
  dhbc_pkg::upd_res_t     upd;

  logic                       in_acc;
  logic                       go;
  logic [dhbc_pkg::BUCKET_IN_W-1:0] bucket_rem;
  logic [BW-1:0]              bucket_idx;
  logic [6:0]                 taxa_n;
  logic [MAX_TAXA-1:0]        taxa_mask;
  logic [dhbc_pkg::BITS_W-1:0] bits_flip;
  logic [MAX_TAXA-1:0]        norm;

  assign in_acc = item.valid && item.ready;
  assign go     = (state == dhbc_pkg::S_LOOKUP) && (!res_valid || result.ready);

  // Bucket index: bucket_hash modulo BUCKETS by compare and subtract.
  always_comb begin
    bucket_rem = item.data.bucket_hash;
    for (int k = dhbc_pkg::BUCKET_IN_W - 1; k >= 0; k--) begin
      if ((longint'(BUCKETS) << k) < (longint'(1) << dhbc_pkg::BUCKET_IN_W)) begin
        if (bucket_rem >= dhbc_pkg::BUCKET_IN_W'(BUCKETS << k)) begin
          bucket_rem = bucket_rem - dhbc_pkg::BUCKET_IN_W'(BUCKETS << k);
        end
      end
    end
  end

  assign bucket_idx = BW'(bucket_rem);

  // Normalized bitstring: optional inversion, then the taxa mask.
  assign taxa_n    = (taxa_count > 7'(MAX_TAXA)) ? 7'(MAX_TAXA) : taxa_count;
  assign bits_flip = item.data.flip ? ~item.data.bits : item.data.bits;

  always_comb begin
    for (int i = 0; i < MAX_TAXA; i++) begin
      taxa_mask[i] = (7'(i) < taxa_n);
    end
  end

  assign norm = bits_flip[MAX_TAXA-1:0] & taxa_mask;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      dhbc_pkg::S_CLEAR: begin
        if (clr_addr == BW'(BUCKETS - 1)) begin
          state_next = dhbc_pkg::S_IDLE;
        end
      end
      dhbc_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = dhbc_pkg::S_LOOKUP;
        end
      end
      dhbc_pkg::S_LOOKUP: begin
        if (go) begin
          state_next = dhbc_pkg::S_IDLE;
        end
      end
      default: state_next = dhbc_pkg::S_CLEAR;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    item.ready = 1'b0;
    ram_addr   = bucket_q;
    ram_we     = 1'b0;
    ram_wdata  = row_new;
    ram_re     = 1'b0;
    unique case (state)
      dhbc_pkg::S_CLEAR: begin
        ram_addr  = clr_addr;
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      dhbc_pkg::S_IDLE: begin
        item.ready = 1'b1;
        ram_addr   = bucket_idx;
        ram_re     = in_acc;
      end
      dhbc_pkg::S_LOOKUP: begin
        ram_we = go && upd.we;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign cfg.ready    = 1'b1;
  assign result.valid = res_valid;
  assign result.data  = res_q;

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dhbc_pkg::S_CLEAR;
      clr_addr    <= '0;
      res_valid   <= 1'b0;
      verify_bits <= 1'b1;
      weighted    <= 1'b0;
      taxa_count  <= 7'd64;
    end else begin
      state <= state_next;
      if (state == dhbc_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (go) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.data.reg_index)
          dhbc_pkg::REG_VERIFY_BITS: verify_bits <= cfg.data.reg_value[0];
          dhbc_pkg::REG_WEIGHTED:    weighted    <= cfg.data.reg_value[0];
          dhbc_pkg::REG_TAXA_COUNT:  taxa_count  <= cfg.data.reg_value;
          default: ;
        endcase
      end
    end
  end

  // Item capture and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      bucket_q <= bucket_idx;
      check_q  <= item.data.check_hash;
      norm_q   <= norm;
      tree_q   <= item.data.tree_index;
      dist_q   <= item.data.distance;
    end
    if (go) begin
      res_q.status       <= upd.status;
      res_q.slot         <= upd.slot;
      res_q.hit_count    <= upd.count;
      res_q.tree_out     <= tree_q;
      res_q.weight_out   <= weighted ? dist_q : 32'd0;
      res_q.weight_valid <= weighted;
    end
  end

  dhbc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_row_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .re    (ram_re),
    .rdata (ram_rdata)
  );

  dhbc_row_update #(
    .WAYS     (WAYS),
    .MAX_TAXA (MAX_TAXA)
  ) u_row_update (
    .row_in  (ram_rdata),
    .check   (check_q),
    .norm    (norm_q),
    .verify  (verify_bits),
    .row_out (row_new),
    .res     (upd)
  );

endmodule

// ===== design/dhbc_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module dhbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/dhbc_row_update.sv =====
// Compares an item against one bucket row and builds the written-back row.
module dhbc_row_update #(
  parameter int WAYS     = 8,
  parameter int MAX_TAXA = 64
) (
  input  logic [$clog2(WAYS+1) + WAYS*(dhbc_pkg::HASH_W + dhbc_pkg::COUNT_W + MAX_TAXA)-1:0]
                                     row_in,
  input  logic [dhbc_pkg::HASH_W-1:0] check,
  input  logic [MAX_TAXA-1:0]        norm,
  input  logic                       verify,
  output logic [$clog2(WAYS+1) + WAYS*(dhbc_pkg::HASH_W + dhbc_pkg::COUNT_W + MAX_TAXA)-1:0]
                                     row_out,
  output dhbc_pkg::upd_res_t         res
);

  localparam int FILL_W  = $clog2(WAYS + 1);
  localparam int SLOT_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRY_W = dhbc_pkg::HASH_W + dhbc_pkg::COUNT_W + MAX_TAXA;
  localparam int CNT_LO  = dhbc_pkg::HASH_W;
  localparam int BITS_LO = dhbc_pkg::HASH_W + dhbc_pkg::COUNT_W;

  logic [FILL_W-1:0]            fill;
  logic [WAYS-1:0]              hit_vec;
  logic                         hit;
  logic [SLOT_W-1:0]            hit_idx;
  logic [ENTRY_W-1:0]           sel;
  logic [dhbc_pkg::COUNT_W-1:0] sel_count;
  logic [dhbc_pkg::COUNT_W-1:0] inc_count;
  logic                         mismatch;
  logic                         do_count;
  logic                         do_new;
  logic [SLOT_W-1:0]            fill_idx;
  logic [7:0]                   slot_wide;

  assign fill     = row_in[FILL_W-1:0];
  assign fill_idx = SLOT_W'(fill);

  // Match vector over the valid entries of the row.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = (FILL_W'(w) < fill) &&
                   (row_in[FILL_W + w*ENTRY_W +: dhbc_pkg::HASH_W] == check);
    end
  end

  // Lowest matching slot wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    sel     = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(w);
        sel     = row_in[FILL_W + w*ENTRY_W +: ENTRY_W];
      end
    end
  end

  assign sel_count = sel[CNT_LO +: dhbc_pkg::COUNT_W];
  assign inc_count = (sel_count == dhbc_pkg::COUNT_MAX) ? sel_count : sel_count + 1'b1;
  assign mismatch  = verify && (sel[BITS_LO +: MAX_TAXA] != norm);
  assign do_count  = hit && !mismatch;
  assign do_new    = !hit && (fill < FILL_W'(WAYS));

  // Row written back: bumped count on a verified hit, appended entry on a miss with a free slot.
  always_comb begin
    row_out = row_in;
    for (int w = 0; w < WAYS; w++) begin
      if (do_count && (SLOT_W'(w) == hit_idx)) begin
        row_out[FILL_W + w*ENTRY_W + CNT_LO +: dhbc_pkg::COUNT_W] = inc_count;
      end
      if (do_new && (SLOT_W'(w) == fill_idx)) begin
        row_out[FILL_W + w*ENTRY_W +: ENTRY_W] = {norm, dhbc_pkg::COUNT_W'(1), check};
      end
    end
    if (do_new) begin
      row_out[FILL_W-1:0] = fill + 1'b1;
    end
  end

  // Status, slot and count of the result.
  always_comb begin
    slot_wide = 8'(hit_idx);
    res.we    = do_count || do_new;
    if (hit) begin
      res.slot = slot_wide[2:0];
      if (mismatch) begin
        res.status = dhbc_pkg::ST_MISMATCH;
        res.count  = sel_count;
      end else begin
        res.status = dhbc_pkg::ST_COUNTED;
        res.count  = inc_count;
      end
    end else if (do_new) begin
      slot_wide  = 8'(fill_idx);
      res.slot   = slot_wide[2:0];
      res.status = dhbc_pkg::ST_NEW;
      res.count  = dhbc_pkg::COUNT_W'(1);
    end else begin
      res.slot   = 3'd0;
      res.status = dhbc_pkg::ST_FULL;
      res.count  = '0;
    end
  end

endmodule
